// ===== sv/bfa_pkg.sv =====
// bfa_pkg: request/result types, codes and command/status structs for the
// bitmap frame allocator. No dependencies.
`default_nettype none
package bfa_pkg;
	localparam int unsigned FRAME_W = 18;
	localparam int unsigned COUNT_W = 19;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_FREE    = 2'd1,
		REQ_RELEASE = 2'd2,
		REQ_RESERVE = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_OOM     = 2'd1,
		ST_IGNORED = 2'd2,
		ST_SPARE   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [FRAME_W-1:0] frame_index;
		logic [COUNT_W-1:0] range_start;
		logic [COUNT_W-1:0] range_end;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] alloc_frame;
		logic [1:0]         status;
		logic [COUNT_W-1:0] free_frames;
		logic [COUNT_W-1:0] released_frames;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture request
		logic clr_read;   // reset word pointer at end of clear pass
		logic clr_write;  // write all-ones word
		logic rd_word;    // issue read of current word
		logic exec;       // act on the registered word
		logic adv;        // step word pointer
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic word_last;  // current word is the final one to visit
		logic hit;        // alloc found a free bit in the word
		logic empty;      // range request touches nothing
	} sts_t;
endpackage
`default_nettype wire

// ===== sv/bfa_datapath.sv =====
// bfa_datapath: used-map memory, word pointer, counters and result register.
// Depends on bfa_pkg.
`default_nettype none
module bfa_datapath #(
	parameter int unsigned NUM_FRAMES = 262144
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bfa_pkg::req_t req,
	input  wire bfa_pkg::cmd_t cmd,
	output bfa_pkg::sts_t      sts,
	output bfa_pkg::rsp_t      rsp
);
	localparam int unsigned WORDS = (NUM_FRAMES + 63) / 64;
	localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned FW = $clog2(NUM_FRAMES + 1);
	localparam int unsigned CW = bfa_pkg::COUNT_W;
	localparam int unsigned XW = ((FW > CW) ? FW : CW) + 1;
	localparam logic [FW-1:0] NF = FW'(NUM_FRAMES);
	localparam int unsigned FRAME_W_L = bfa_pkg::FRAME_W;

	logic [63:0] mem [WORDS];
	logic [63:0] rdata_q;
	logic [AW-1:0] ptr_q;
	logic [1:0] kind_q;
	logic [FW-1:0] lo_q, hi_q; // frame range [lo,hi)
	logic [CW-1:0] free_q, total_q;
	logic [FRAME_W_L-1:0] grant_q;
	logic [1:0] stat_q;

	// request decode with clamp, wide enough for any field value
	logic [XW-1:0] rs_w, re_w, fi_w;
	logic [FW-1:0] re_c, rs_c;
	always_comb begin
		rs_w = XW'(req.range_start);
		re_w = XW'(req.range_end);
		fi_w = XW'(req.frame_index);
		re_c = (re_w > XW'(NUM_FRAMES)) ? NF : re_w[FW-1:0];
		rs_c = (rs_w > XW'(NUM_FRAMES)) ? NF : rs_w[FW-1:0];
	end

	// word-level masks for range
	logic [FW+5:0] wbase;
	logic [63:0] rmask, avail, newword, cnt_bits;
	logic [6:0] nbits;
	logic [5:0] fbit;
	logic found;
	always_comb begin
		wbase = (FW+6)'(ptr_q) << 6;
		for (int b = 0; b < 64; b++) begin
			rmask[b] = ((wbase + (FW+6)'(b)) >= (FW+6)'(lo_q))
				&& ((wbase + (FW+6)'(b)) < (FW+6)'(hi_q));
		end
		avail = ~rdata_q;
		if (ptr_q == '0) avail[0] = 1'b0;
		found = |avail;
		fbit = '0;
		for (int b = 63; b >= 0; b--) if (avail[b]) fbit = 6'(b);
		// release counts every frame in range, reserve only the free ones
		if (kind_q == bfa_pkg::REQ_RELEASE) cnt_bits = rmask;
		else cnt_bits = rmask & ~rdata_q;
		nbits = 7'($countones(cnt_bits));
		if (kind_q == bfa_pkg::REQ_RELEASE) newword = rdata_q & ~rmask;
		else newword = rdata_q | rmask;
	end

	logic [FW+5:0] fidx_full;
	assign fidx_full = wbase + (FW+6)'(fbit);
	logic [CW:0] up_free, up_tot;
	always_comb begin
		up_free = (CW+1)'(free_q) + (CW+1)'(nbits);
		up_tot = (CW+1)'(total_q) + (CW+1)'(nbits);
	end

	always_comb begin
		sts.clr_last = (ptr_q == AW'(WORDS - 1));
		sts.hit = found && (fidx_full < (FW+6)'(NUM_FRAMES));
		sts.empty = (lo_q >= hi_q);
		if (kind_q == bfa_pkg::REQ_ALLOC || kind_q == bfa_pkg::REQ_FREE)
			sts.word_last = 1'b1;
		else
			sts.word_last = ((FW+6)'(hi_q) <= wbase + 7'd64);
		if (kind_q == bfa_pkg::REQ_ALLOC)
			sts.word_last = (ptr_q == AW'(WORDS - 1)) || sts.hit;
	end

	// memory
	always_ff @(posedge clk) begin
		if (cmd.clr_write) mem[ptr_q] <= '1;
		else if (cmd.exec) begin
			unique case (kind_q)
				bfa_pkg::REQ_ALLOC:
					if (sts.hit) mem[ptr_q] <= rdata_q | (64'd1 << fbit);
				bfa_pkg::REQ_FREE:
					if (stat_q == bfa_pkg::ST_DONE)
						mem[ptr_q] <= rdata_q & ~(64'd1 << lo_q[5:0]);
				default: mem[ptr_q] <= newword;
			endcase
		end
		if (cmd.rd_word) rdata_q <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			free_q <= '0;
			total_q <= '0;
			kind_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			grant_q <= '0;
			stat_q <= bfa_pkg::ST_DONE;
		end else begin
			if (cmd.load) begin
				kind_q <= req.req_type;
				grant_q <= '0;
				stat_q <= bfa_pkg::ST_DONE;
				if (req.req_type == bfa_pkg::REQ_FREE) begin
					lo_q <= fi_w[FW-1:0];
					hi_q <= fi_w[FW-1:0];
					ptr_q <= AW'(fi_w >> 6);
					if (fi_w >= XW'(NUM_FRAMES)) stat_q <= bfa_pkg::ST_IGNORED;
				end else begin
					lo_q <= rs_c;
					hi_q <= re_c;
					ptr_q <= (req.req_type == bfa_pkg::REQ_ALLOC) ? '0 : AW'(rs_c >> 6);
				end
			end else if (cmd.exec) begin
				unique case (kind_q)
					bfa_pkg::REQ_ALLOC:
						if (sts.hit) begin
							grant_q <= fidx_full[FRAME_W_L-1:0];
							if (free_q != '0) free_q <= free_q - 1'b1;
						end else if (sts.word_last) stat_q <= bfa_pkg::ST_OOM;
					bfa_pkg::REQ_FREE:
						if (stat_q == bfa_pkg::ST_DONE) begin
							if (!rdata_q[lo_q[5:0]]) stat_q <= bfa_pkg::ST_IGNORED;
							else if (free_q != bfa_pkg::COUNT_MAX) free_q <= free_q + 1'b1;
						end
					bfa_pkg::REQ_RELEASE: begin
						free_q <= up_free[CW] ? bfa_pkg::COUNT_MAX : up_free[CW-1:0];
						total_q <= up_tot[CW] ? bfa_pkg::COUNT_MAX : up_tot[CW-1:0];
					end
					default:
						free_q <= (free_q > CW'(nbits)) ? free_q - CW'(nbits) : '0;
				endcase
			end
			if (cmd.adv) ptr_q <= ptr_q + 1'b1;
			else if (cmd.clr_read) ptr_q <= '0;
		end
	end

	assign rsp.alloc_frame = grant_q;
	assign rsp.status = stat_q;
	assign rsp.free_frames = free_q;
	assign rsp.released_frames = total_q;
endmodule
`default_nettype wire

// ===== sv/bfa_ctrl.sv =====
// bfa_ctrl: sequencer for clear pass and word walks. Depends on bfa_pkg.
`default_nettype none
module bfa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire bfa_pkg::sts_t sts,
	input  wire logic [1:0]    kind,
	output bfa_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);
	typedef enum logic [2:0] {S_CLR, S_IDLE, S_READ, S_WAIT, S_EXEC} state_t;
	state_t state_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLR:  begin cmd.clr_write = 1'b1; cmd.adv = !sts.clr_last;
				cmd.clr_read = sts.clr_last; end
			S_IDLE: cmd.load = start;
			S_READ: cmd.rd_word = 1'b1;
			S_WAIT: ;
			S_EXEC: begin
				cmd.exec = 1'b1;
				cmd.adv = !sts.word_last && kind != bfa_pkg::REQ_FREE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			busy <= 1'b1;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_CLR: if (sts.clr_last) begin state_q <= S_IDLE; busy <= 1'b0; end
				S_IDLE: if (start) begin state_q <= S_READ; busy <= 1'b1; end
				S_READ: begin
					if ((kind == bfa_pkg::REQ_RELEASE || kind == bfa_pkg::REQ_RESERVE)
						&& sts.empty) begin
						state_q <= S_IDLE; busy <= 1'b0; done <= 1'b1;
					end else state_q <= S_WAIT;
				end
				S_WAIT: state_q <= S_EXEC;
				S_EXEC: if (sts.word_last || kind == bfa_pkg::REQ_FREE) begin
					state_q <= S_IDLE; busy <= 1'b0; done <= 1'b1;
				end else state_q <= S_READ;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/bitmap_frame_allocator.sv =====
// bitmap_frame_allocator: top level, joins controller and datapath.
// Depends on bfa_pkg, bfa_ctrl, bfa_datapath.
`default_nettype none
// Usage:
//  A request (req: kind, frame index, range) is taken at a clock edge where
//  start is high and busy is low. One result per transaction appears on rsp
//  for exactly one cycle with done high; the receiver cannot stall it.
//  Work per transaction: free visits one map word; allocate visits 64-frame
//  map words from the first up to the one with the first free bit (or all of
//  them); release/reserve visit every map word the range covers, and finish
//  straight after the read state when the range is empty. The loop is a read, a
//  registered word, then a read-modify-write on the single map memory port.
//  busy drops together with done, so the next request can be taken at the
//  edge that takes the result.
//  Reset: busy stays high while a clearing pass writes every map word to all
//  ones (every frame used); the counters are zeroed at once. Requests are
//  taken only after that pass.
module bitmap_frame_allocator #(
	parameter int unsigned NUM_FRAMES = 262144
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire bfa_pkg::req_t req,
	output logic               busy,
	output logic               done,
	output bfa_pkg::rsp_t      rsp
);
	bfa_pkg::cmd_t cmd;
	bfa_pkg::sts_t sts;
	logic [1:0] kind_q;

	// request kind held for the controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) kind_q <= '0;
		else if (cmd.load) kind_q <= req.req_type;
	end

	bfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .kind(kind_q),
		.cmd(cmd), .busy(busy), .done(done)
	);

	bfa_datapath #(.NUM_FRAMES(NUM_FRAMES)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .sts(sts), .rsp(rsp)
	);
endmodule
`default_nettype wire

// ===== sim/bitmap_frame_allocator_check.sv =====
// Checker for bitmap_frame_allocator: mirrors the used map and counters, predicts
// one result per accepted transaction and compares it with rsp. Depends on bfa_pkg.
`timescale 1ns / 100ps
module bitmap_frame_allocator_check #(
	parameter int unsigned NUM_FRAMES = 262144
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          busy,
	input  wire bfa_pkg::req_t req,
	input  wire logic          done,
	input  wire bfa_pkg::rsp_t rsp,
	output int                 errors,
	output int                 pending
);
	localparam int unsigned WORDS = (NUM_FRAMES + 63) / 64;

	logic [63:0]                 used_words [WORDS];
	logic [bfa_pkg::COUNT_W-1:0] free_cnt;
	logic [bfa_pkg::COUNT_W-1:0] total_cnt;
	bfa_pkg::rsp_t               expected_rsp [$];

	task automatic frame_alloc_predict(input bfa_pkg::req_t r, output bfa_pkg::rsp_t e);
		int unsigned re, f, w, b;
		logic [63:0] avail;
		bit found;
		re = 32'(r.range_end);
		if (re > NUM_FRAMES) re = NUM_FRAMES;
		e = '0;
		e.status = bfa_pkg::ST_DONE;
		case (bfa_pkg::req_kind_t'(r.req_type))
			bfa_pkg::REQ_ALLOC: begin
				found = 0;
				for (w = 0; w < WORDS && !found; w++) begin
					avail = ~used_words[w];
					if (w == 0) avail[0] = 1'b0;
					if (avail != '0) begin
						for (b = 0; b < 64 && !found; b++) begin
							if (avail[b]) begin
								found = 1;
								f = w * 64 + b;
							end
						end
					end
				end
				if (!found || f >= NUM_FRAMES) begin
					e.status = bfa_pkg::ST_OOM;
				end else begin
					used_words[f >> 6][f & 63] = 1'b1;
					if (free_cnt != '0) free_cnt = free_cnt - 1'b1;
					e.alloc_frame = f[bfa_pkg::FRAME_W-1:0];
				end
			end
			bfa_pkg::REQ_FREE: begin
				f = 32'(r.frame_index);
				if (f >= NUM_FRAMES || !used_words[f >> 6][f & 63]) begin
					e.status = bfa_pkg::ST_IGNORED;
				end else begin
					used_words[f >> 6][f & 63] = 1'b0;
					if (free_cnt != bfa_pkg::COUNT_MAX) free_cnt = free_cnt + 1'b1;
				end
			end
			bfa_pkg::REQ_RELEASE: begin
				// every visited frame counts, already free or not
				for (f = 32'(r.range_start); f < re; f++) begin
					used_words[f >> 6][f & 63] = 1'b0;
					if (total_cnt != bfa_pkg::COUNT_MAX) total_cnt = total_cnt + 1'b1;
					if (free_cnt != bfa_pkg::COUNT_MAX) free_cnt = free_cnt + 1'b1;
				end
			end
			default: begin
				for (f = 32'(r.range_start); f < re; f++) begin
					if (!used_words[f >> 6][f & 63]) begin
						used_words[f >> 6][f & 63] = 1'b1;
						if (free_cnt != '0) free_cnt = free_cnt - 1'b1;
					end
				end
			end
		endcase
		e.free_frames     = free_cnt;
		e.released_frames = total_cnt;
	endtask

	always @(posedge clk or negedge arst_n) begin
		bfa_pkg::rsp_t e;
		if (!arst_n) begin
			foreach (used_words[i]) used_words[i] = '1;
			free_cnt  = '0;
			total_cnt = '0;
			expected_rsp.delete();
			errors = 0;
			pending = 0;
		end else begin
			// a result seen at this edge belongs to an earlier transaction
			if (done) begin
				if (expected_rsp.size() == 0) begin
					$error("result with no transaction outstanding");
					errors++;
				end else begin
					e = expected_rsp.pop_front();
					if (rsp.alloc_frame !== e.alloc_frame) begin
						$error("alloc_frame: expected %0d, got %0d", e.alloc_frame,
							rsp.alloc_frame);
						errors++;
					end
					if (rsp.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, rsp.status);
						errors++;
					end
					if (rsp.free_frames !== e.free_frames) begin
						$error("free_frames: expected %0d, got %0d", e.free_frames,
							rsp.free_frames);
						errors++;
					end
					if (rsp.released_frames !== e.released_frames) begin
						$error("released_frames: expected %0d, got %0d",
							e.released_frames, rsp.released_frames);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				frame_alloc_predict(req, e);
				expected_rsp.push_back(e);
			end
			pending = expected_rsp.size();
		end
	end
endmodule

// ===== sim/bitmap_frame_allocator_test.sv =====
// Top of the bitmap_frame_allocator testbench: clock, reset, directed and random
// transactions, verdict. Depends on bfa_pkg, bitmap_frame_allocator and its checker.
`timescale 1ns / 100ps
module bitmap_frame_allocator_test;
	localparam int unsigned NUM_FRAMES = 262144;
	localparam int          RAND_ITEMS = 1300;
	// a transaction walks at most the whole map plus an idle gap; the limit is
	// about three times that bound for every transaction, clearing pass
	// included
	localparam int          CYCLE_LIMIT = 50000000;

	logic clk;
	logic arst_n;
	logic start;
	bfa_pkg::req_t req;
	logic busy;
	logic done;
	bfa_pkg::rsp_t rsp;
	int   errors;
	int   pending;
	int   cycles;
	bit   burst;  // no idle gaps while set

	bitmap_frame_allocator #(.NUM_FRAMES(NUM_FRAMES)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	bitmap_frame_allocator_check #(.NUM_FRAMES(NUM_FRAMES)) u_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Issue one transaction: optional idle gap, then hold start until busy is low
	// at an edge. start stays high into the next transaction when it has no gap.
	task automatic issue(input bfa_pkg::req_t r);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
	endtask

	function automatic bfa_pkg::req_t mk(input bfa_pkg::req_kind_t k,
		input int unsigned fi, input int unsigned rs, input int unsigned re);
		bfa_pkg::req_t r;
		r.req_type    = k;
		r.frame_index = fi[bfa_pkg::FRAME_W-1:0];
		r.range_start = rs[bfa_pkg::COUNT_W-1:0];
		r.range_end   = re[bfa_pkg::COUNT_W-1:0];
		return r;
	endfunction

	// Random transaction: most activity sits in a low window of the map so that
	// allocate finds frames quickly and frees hit used frames; long walks are rare.
	function automatic bfa_pkg::req_t rand_req();
		bfa_pkg::req_t r;
		logic [63:0] raw;
		int unsigned p, rs, re, lim;
		raw = {$urandom, $urandom};
		r = raw[$bits(bfa_pkg::req_t)-1:0];
		p = $urandom_range(0, 99);
		if (p < 30) r.req_type = bfa_pkg::REQ_ALLOC;
		else if (p < 60) r.req_type = bfa_pkg::REQ_FREE;
		else if (p < 80) r.req_type = bfa_pkg::REQ_RELEASE;
		else r.req_type = bfa_pkg::REQ_RESERVE;
		if ($urandom_range(0, 9) != 0)
			r.frame_index = bfa_pkg::FRAME_W'($urandom_range(0, 4095));
		if ($urandom_range(0, 99) < 90) begin
			rs = $urandom_range(0, 4095);
			re = ($urandom_range(0, 19) == 0) ? $urandom_range(0, rs) :
				rs + $urandom_range(0, 150);
			r.range_start = rs[bfa_pkg::COUNT_W-1:0];
			r.range_end   = re[bfa_pkg::COUNT_W-1:0];
		end else begin
			rs  = 32'(r.range_start);
			re  = 32'(r.range_end);
			lim = (re > NUM_FRAMES) ? NUM_FRAMES : re;
			// keep long walks to about one in a hundred of these
			if (lim > rs && lim - rs > 4096 && $urandom_range(0, 99) != 0)
				r.range_start = bfa_pkg::COUNT_W'(lim - $urandom_range(0, 4096));
		end
		return r;
	endfunction

	initial begin
		int wait_cycles;
		cycles = 0;
		burst  = 1'b0;
		start  = 1'b0;
		req    = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed transactions
		issue(mk(bfa_pkg::REQ_ALLOC, 0, 0, 0));             // out of memory after reset
		issue(mk(bfa_pkg::REQ_FREE, 5, 0, 0));              // used frame freed
		issue(mk(bfa_pkg::REQ_FREE, 5, 0, 0));              // already free: ignored
		issue(mk(bfa_pkg::REQ_FREE, 262143, 0, 0));         // top frame
		issue(mk(bfa_pkg::REQ_RELEASE, 0, 10, 10));         // empty range
		issue(mk(bfa_pkg::REQ_RELEASE, 0, 20, 10));         // start above end
		issue(mk(bfa_pkg::REQ_RELEASE, 0, 0, 524287));      // end clamped, whole map
		issue(mk(bfa_pkg::REQ_RELEASE, 0, 0, 262144));      // counters saturate
		issue(mk(bfa_pkg::REQ_RELEASE, 0, 262143, 262144)); // last frame only
		issue(mk(bfa_pkg::REQ_ALLOC, 0, 0, 0));             // frame 0 is skipped
		issue(mk(bfa_pkg::REQ_RESERVE, 0, 0, 524287));      // take the whole map back
		issue(mk(bfa_pkg::REQ_ALLOC, 0, 0, 0));             // out of memory again
		issue(mk(bfa_pkg::REQ_RELEASE, 0, 0, 1));           // only frame 0 free
		issue(mk(bfa_pkg::REQ_ALLOC, 0, 0, 0));             // frame 0 never granted
		issue(mk(bfa_pkg::REQ_FREE, 0, 0, 0));              // frame 0 already free
		issue(mk(bfa_pkg::REQ_RESERVE, 0, 0, 1));
		issue(mk(bfa_pkg::REQ_RELEASE, 0, 524287, 524287)); // start beyond map
		issue(mk(bfa_pkg::REQ_RESERVE, 0, 524287, 0));      // reserve, start above end
		issue(bfa_pkg::req_t'('1));                         // all fields at maximum
		issue(mk(bfa_pkg::REQ_RELEASE, 0, 0, 4096));        // seed the low window
		issue(mk(bfa_pkg::REQ_ALLOC, 0, 0, 0));
		issue(mk(bfa_pkg::REQ_FREE, 1, 0, 0));

		// random transactions, with stretches of back-to-back traffic
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 100 == 0) burst = ($urandom_range(0, 2) == 0);
			issue(rand_req());
		end
		start <= 1'b0;

		// let the checker record the last transaction, then wait for its result
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// short tail to catch a stray result
		wait_cycles = 0;
		while (wait_cycles < 50) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (errors == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/bfa_pkg.sv
sv/bfa_datapath.sv
sv/bfa_ctrl.sv
sv/bitmap_frame_allocator.sv
sim/bitmap_frame_allocator_check.sv
sim/bitmap_frame_allocator_test.sv
